/* rtl/lexical_path_normalizer_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the lexical path normaliser.
// They compile to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef LEXICAL_PATH_NORMALIZER_UNIT_ASSERT_SVH
`define LEXICAL_PATH_NORMALIZER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define LPN_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lpn: same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define LPN_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lpn: next-cycle check failed");
`else
`define LPN_ASSERT_IMP(label, clk, rst_n, pre, post)
`define LPN_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

/* rtl/lpn_pkg.sv */
// ---------------------------------------------------------------------------
// lpn_pkg
// Shared constants, codes and types of the lexical path normaliser.
// ---------------------------------------------------------------------------
package lpn_pkg;

    // Depth of the normalised path buffer.
    localparam int BUF_LEN = 4096;
    // Width of lengths, positions and read indexes.
    localparam int LEN_W = 12;
    // Highest position at which no byte may be written any more.
    localparam logic [LEN_W-1:0] WP_MAX = LEN_W'(BUF_LEN - 1);

    localparam logic OP_PATH = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NOT_ABS  = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    localparam logic [7:0]  CH_SLASH    = 8'h2F;
    localparam logic [15:0] HEAD_DOT    = 16'h002E;
    localparam logic [15:0] HEAD_DOTDOT = 16'h2E2E;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_POP_RD,
        ST_POP_CHK,
        ST_RD_WAIT,
        ST_RESULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic write_step;
        logic pop_read;
        logic pop_check;
        logic pop_done;
        logic load_result;
        logic load_read;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic plan_read;
        logic plan_writes;
        logic plan_pop;
        logic plan_result;
        logic last_write;
        logic pop_more;
        logic pop_slash;
        logic pend_result;
        logic out_free;
    } t_sts;

endpackage

/* rtl/lexical_path_normalizer_unit.sv */
// ---------------------------------------------------------------------------
// lexical_path_normalizer_unit
// Rewrites an absolute path, streamed one byte per request, into canonical
// form in a 4096-byte buffer, and reads bytes of that buffer back.
// ---------------------------------------------------------------------------
// Input channel: i_valid / o_stall with i_op, i_ch, i_last, i_index. A path
// request (op 0) carries one byte; the byte flagged last yields a result with
// the status and the normalised length. A read request (op 1) yields a result
// with one buffer byte in o_data.
// Output channel: o_valid / i_stall with o_status, o_length, o_data, held in
// an output register, so a further request is taken while a result waits.
// A path byte is taken in ST_IDLE; each buffer byte that it queues (up to 4
// for a segment's third byte) is then written in ST_WRITE, and the last
// byte's result loaded in ST_RESULT. A '..' segment walks back through the
// buffer's single port, ST_POP_RD then ST_POP_CHK per byte removed, and a
// last ST_POP_RD at the root. A read registers its byte; ST_RD_WAIT loads it.
// Reset clears the controller, the segment state and the output valid; the
// buffer itself is not cleared, as reads are gated by the current length.
// While i_stall holds a result, a request needing a result waits in the
// controller with o_stall high.
// ---------------------------------------------------------------------------
`include "lexical_path_normalizer_unit_assert.svh"

module lexical_path_normalizer_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_op,
    input  logic [7:0]                i_ch,
    input  logic                      i_last,
    input  logic [lpn_pkg::LEN_W-1:0] i_index,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [1:0]                o_status,
    output logic [lpn_pkg::LEN_W-1:0] o_length,
    output logic [7:0]                o_data
);

    lpn_pkg::t_cmd cmd;
    lpn_pkg::t_sts sts;

    lpn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lpn_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (i_op),
        .i_ch     (i_ch),
        .i_last   (i_last),
        .i_index  (i_index),
        .i_stall  (i_stall),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_valid  (o_valid),
        .o_status (o_status),
        .o_length (o_length),
        .o_data   (o_data)
    );

    // A failed path never reports a length.
    `LPN_ASSERT_IMP(a_len_on_ok, i_clk, i_rst_n, o_valid && (o_status != lpn_pkg::STATUS_OK), o_length == '0)
    // Buffer data only comes with a read result.
    `LPN_ASSERT_IMP(a_data_on_read, i_clk, i_rst_n, o_valid && (o_data != 8'd0), (o_status == lpn_pkg::STATUS_OK) && (o_length == '0))
    // Accepting the last byte of a path always takes the controller out of ST_IDLE, so the input stalls for its result.
    `LPN_ASSERT_NXT(a_last_busy, i_clk, i_rst_n, i_valid && !o_stall && (i_op == lpn_pkg::OP_PATH) && i_last, o_stall)

endmodule

/* rtl/lpn_ctrl.sv */
// ---------------------------------------------------------------------------
// lpn_ctrl
// Sequencer of the path normaliser: accepts requests and steps the datapath
// through buffer writes, the parent-segment pop, reads and result loads.
// ---------------------------------------------------------------------------
module lpn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  lpn_pkg::t_sts i_sts,
    output lpn_pkg::t_cmd o_cmd
);

    lpn_pkg::t_state r_state;
    lpn_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpn_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpn_pkg::ST_IDLE: begin
                if (i_valid) begin
                    priority if (i_sts.plan_read) begin
                        n_state = lpn_pkg::ST_RD_WAIT;
                    end else if (i_sts.plan_writes) begin
                        n_state = lpn_pkg::ST_WRITE;
                    end else if (i_sts.plan_pop) begin
                        n_state = lpn_pkg::ST_POP_RD;
                    end else if (i_sts.plan_result) begin
                        n_state = lpn_pkg::ST_RESULT;
                    end else begin
                        n_state = lpn_pkg::ST_IDLE;
                    end
                end
            end
            lpn_pkg::ST_WRITE: begin
                if (i_sts.last_write) begin
                    n_state = i_sts.pend_result ? lpn_pkg::ST_RESULT : lpn_pkg::ST_IDLE;
                end
            end
            lpn_pkg::ST_POP_RD: begin
                if (i_sts.pop_more) begin
                    n_state = lpn_pkg::ST_POP_CHK;
                end else begin
                    n_state = i_sts.pend_result ? lpn_pkg::ST_RESULT : lpn_pkg::ST_IDLE;
                end
            end
            lpn_pkg::ST_POP_CHK: begin
                if (i_sts.pop_slash) begin
                    n_state = i_sts.pend_result ? lpn_pkg::ST_RESULT : lpn_pkg::ST_IDLE;
                end else begin
                    n_state = lpn_pkg::ST_POP_RD;
                end
            end
            lpn_pkg::ST_RD_WAIT: begin
                if (i_sts.out_free) begin
                    n_state = lpn_pkg::ST_IDLE;
                end
            end
            lpn_pkg::ST_RESULT: begin
                if (i_sts.out_free) begin
                    n_state = lpn_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lpn_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            lpn_pkg::ST_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            lpn_pkg::ST_WRITE: begin
                o_cmd.write_step = 1'b1;
            end
            lpn_pkg::ST_POP_RD: begin
                o_cmd.pop_read = i_sts.pop_more;
                o_cmd.pop_done = !i_sts.pop_more;
            end
            lpn_pkg::ST_POP_CHK: begin
                o_cmd.pop_check = 1'b1;
            end
            lpn_pkg::ST_RD_WAIT: begin
                o_cmd.load_read = i_sts.out_free;
            end
            lpn_pkg::ST_RESULT: begin
                o_cmd.load_result = i_sts.out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/lpn_datapath.sv */
// ---------------------------------------------------------------------------
// lpn_datapath
// Segment tracking, the normalised path buffer, the pending write queue,
// the pop pointer and the output register of the path normaliser.
// ---------------------------------------------------------------------------
module lpn_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_op,
    input  logic [7:0]                i_ch,
    input  logic                      i_last,
    input  logic [lpn_pkg::LEN_W-1:0] i_index,
    input  logic                      i_stall,
    input  lpn_pkg::t_cmd             i_cmd,
    output lpn_pkg::t_sts             o_sts,
    output logic                      o_valid,
    output logic [1:0]                o_status,
    output logic [lpn_pkg::LEN_W-1:0] o_length,
    output logic [7:0]                o_data
);

    // Path buffer, undefined until written.
    logic [7:0] r_mem [lpn_pkg::BUF_LEN];
    logic [7:0] r_rdata;

    logic [lpn_pkg::LEN_W-1:0] r_wp;
    logic [1:0]                r_count;
    logic [15:0]               r_head;
    logic                      r_first;
    logic [1:0]                r_err;
    logic [7:0]                r_q [4];
    logic [2:0]                r_qn;
    logic [lpn_pkg::LEN_W-1:0] r_pop_pos;
    logic                      r_pend;
    logic                      r_rd_ok;
    logic                      r_out_valid;
    logic [1:0]                r_out_status;
    logic [lpn_pkg::LEN_W-1:0] r_out_length;
    logic [7:0]                r_out_data;

    // Plan for the item on the input.
    logic [7:0]  plan_q [4];
    logic [2:0]  plan_qn;
    logic        plan_pop;
    logic        p_first;
    logic [1:0]  p_err;
    logic [1:0]  p_count;
    logic [15:0] p_head;
    logic [lpn_pkg::LEN_W-1:0] p_wp;
    logic        do_fin;
    logic [1:0]  fin_count;
    logic [15:0] fin_head;
    logic        sep;

    logic path_acc;
    logic read_acc;
    logic mem_we;
    logic mem_re;
    logic [lpn_pkg::LEN_W-1:0] rd_addr;
    logic out_free;

    assign path_acc = i_cmd.accept && (i_op == lpn_pkg::OP_PATH);
    assign read_acc = i_cmd.accept && (i_op == lpn_pkg::OP_READ);
    // A kept segment gets a leading slash unless it starts at the root.
    assign sep      = (r_wp > lpn_pkg::LEN_W'(1));
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        plan_q    = '{default: '0};
        plan_qn   = 3'd0;
        plan_pop  = 1'b0;
        p_first   = r_first;
        p_err     = r_err;
        p_count   = r_count;
        p_head    = r_head;
        p_wp      = r_wp;
        do_fin    = 1'b0;
        fin_count = r_count;
        fin_head  = r_head;
        if (r_first) begin
            p_first = 1'b0;
            p_count = 2'd0;
            p_head  = '0;
            p_wp    = '0;
            if (i_ch == lpn_pkg::CH_SLASH) begin
                p_err     = lpn_pkg::STATUS_OK;
                plan_q[0] = lpn_pkg::CH_SLASH;
                plan_qn   = 3'd1;
            end else begin
                p_err = lpn_pkg::STATUS_NOT_ABS;
            end
        end else if (r_err == lpn_pkg::STATUS_OK) begin
            if (i_ch == lpn_pkg::CH_SLASH) begin
                do_fin  = 1'b1;
                p_count = 2'd0;
                p_head  = '0;
            end else if (r_count < 2'd2) begin
                p_head    = {r_head[7:0], i_ch};
                p_count   = r_count + 2'd1;
                do_fin    = i_last;
                fin_count = p_count;
                fin_head  = p_head;
            end else if (r_count == 2'd2) begin
                // Third byte: the segment is now known to be kept.
                if (sep) begin
                    plan_q[plan_qn[1:0]] = lpn_pkg::CH_SLASH;
                    plan_qn              = plan_qn + 3'd1;
                end
                plan_q[plan_qn[1:0]] = r_head[15:8];
                plan_qn              = plan_qn + 3'd1;
                plan_q[plan_qn[1:0]] = r_head[7:0];
                plan_qn              = plan_qn + 3'd1;
                plan_q[plan_qn[1:0]] = i_ch;
                plan_qn              = plan_qn + 3'd1;
                p_count              = 2'd3;
            end else begin
                plan_q[0] = i_ch;
                plan_qn   = 3'd1;
            end
            if (do_fin) begin
                if (fin_count == 2'd1 && fin_head != lpn_pkg::HEAD_DOT) begin
                    if (sep) begin
                        plan_q[plan_qn[1:0]] = lpn_pkg::CH_SLASH;
                        plan_qn              = plan_qn + 3'd1;
                    end
                    plan_q[plan_qn[1:0]] = fin_head[7:0];
                    plan_qn              = plan_qn + 3'd1;
                end else if (fin_count == 2'd2) begin
                    if (fin_head == lpn_pkg::HEAD_DOTDOT) begin
                        plan_pop = 1'b1;
                    end else begin
                        if (sep) begin
                            plan_q[plan_qn[1:0]] = lpn_pkg::CH_SLASH;
                            plan_qn              = plan_qn + 3'd1;
                        end
                        plan_q[plan_qn[1:0]] = fin_head[15:8];
                        plan_qn              = plan_qn + 3'd1;
                        plan_q[plan_qn[1:0]] = fin_head[7:0];
                        plan_qn              = plan_qn + 3'd1;
                    end
                end
            end
        end
        if (i_last) begin
            p_first = 1'b1;
            p_count = 2'd0;
            p_head  = '0;
        end
    end

    // Buffer port: writes drain the queue, reads serve read requests and the pop.
    assign mem_we  = i_cmd.write_step && (r_err == lpn_pkg::STATUS_OK) && (r_wp != lpn_pkg::WP_MAX);
    assign mem_re  = i_cmd.pop_read || read_acc;
    assign rd_addr = i_cmd.pop_read ? (r_pop_pos - lpn_pkg::LEN_W'(1)) : i_index;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp] <= r_q[0];
        end
        if (mem_re) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_count     <= 2'd0;
            r_head      <= '0;
            r_first     <= 1'b1;
            r_err       <= lpn_pkg::STATUS_OK;
            r_qn        <= 3'd0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (path_acc) begin
                r_wp    <= p_wp;
                r_count <= p_count;
                r_head  <= p_head;
                r_first <= p_first;
                r_err   <= p_err;
                r_qn    <= plan_qn;
                r_pend  <= i_last;
            end
            if (i_cmd.write_step) begin
                r_qn <= r_qn - 3'd1;
                if (r_err == lpn_pkg::STATUS_OK) begin
                    if (r_wp == lpn_pkg::WP_MAX) begin
                        r_err <= lpn_pkg::STATUS_TOO_LONG;
                    end else begin
                        r_wp <= r_wp + lpn_pkg::LEN_W'(1);
                    end
                end
            end
            if (i_cmd.pop_check && (r_rdata == lpn_pkg::CH_SLASH)) begin
                r_wp <= r_pop_pos - lpn_pkg::LEN_W'(1);
            end
            if (i_cmd.pop_done) begin
                r_wp <= r_pop_pos;
            end
            if (i_cmd.load_result) begin
                r_pend <= 1'b0;
            end
            if (i_cmd.load_result || i_cmd.load_read) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (path_acc) begin
            r_q       <= plan_q;
            r_pop_pos <= r_wp;
        end
        if (i_cmd.write_step) begin
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
            r_q[2] <= r_q[3];
        end
        if (i_cmd.pop_check && (r_rdata != lpn_pkg::CH_SLASH)) begin
            r_pop_pos <= r_pop_pos - lpn_pkg::LEN_W'(1);
        end
        if (read_acc) begin
            r_rd_ok <= (r_err == lpn_pkg::STATUS_OK) && (i_index < r_wp);
        end
        if (i_cmd.load_result) begin
            r_out_status <= r_err;
            r_out_length <= (r_err == lpn_pkg::STATUS_OK) ? r_wp : '0;
            r_out_data   <= 8'd0;
        end else if (i_cmd.load_read) begin
            r_out_status <= lpn_pkg::STATUS_OK;
            r_out_length <= '0;
            r_out_data   <= r_rd_ok ? r_rdata : 8'd0;
        end
    end

    always_comb begin
        o_sts             = '0;
        o_sts.plan_read   = (i_op == lpn_pkg::OP_READ);
        o_sts.plan_writes = (i_op == lpn_pkg::OP_PATH) && (plan_qn != 3'd0);
        o_sts.plan_pop    = (i_op == lpn_pkg::OP_PATH) && plan_pop;
        o_sts.plan_result = (i_op == lpn_pkg::OP_PATH) && i_last;
        o_sts.last_write  = (r_qn == 3'd1);
        o_sts.pop_more    = (r_pop_pos > lpn_pkg::LEN_W'(1));
        o_sts.pop_slash   = (r_rdata == lpn_pkg::CH_SLASH);
        o_sts.pend_result = r_pend;
        o_sts.out_free    = out_free;
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_length = r_out_length;
    assign o_data   = r_out_data;

endmodule

/* sim/tb_lexical_path_normalizer_unit.sv */
// ---------------------------------------------------------------------------
// tb_lexical_path_normalizer_unit
// Streams paths, mostly absolute, and read-backs into the normaliser. Every
// accepted request is run through a cycle-free predictor of the canonical
// path buffer. Each result is compared field by field with the oldest
// prediction. Both handshake sides idle at random, and once the receiver
// holds off long enough for the block to fill up and stall its input.
// ---------------------------------------------------------------------------
module tb_lexical_path_normalizer_unit;
    import lpn_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int RANDOM_REQS    = 850;
    localparam int PRESSURE_HOLD  = 400;
    localparam logic [7:0] CH_DOT = 8'h2E;

    typedef struct packed {
        logic [1:0]       status;
        logic [LEN_W-1:0] length;
        logic [7:0]       data;
    } t_result;

    // Predicts the normalised buffer and the result of each request.
    class path_scoreboard;
        logic [7:0] norm_mem [BUF_LEN];
        int         wr_pos = 0;
        int         seg_start = 0;
        int         seg_cnt = 0;
        logic [15:0] seg_head = '0;
        bit         at_path_start = 1'b1;
        logic [1:0] err = STATUS_OK;
        t_result    pending [$];
        int         errors = 0;

        function void put_byte(logic [7:0] b);
            if (err != STATUS_OK) return;
            if (wr_pos + 1 >= BUF_LEN) begin
                err = STATUS_TOO_LONG;
                return;
            end
            norm_mem[wr_pos] = b;
            wr_pos++;
        endfunction

        // No separator is needed while the segment sits directly at the root.
        function void put_sep();
            if (seg_start > 1) put_byte(CH_SLASH);
        endfunction

        function void close_segment();
            int o;
            if (err == STATUS_OK) begin
                if (seg_cnt == 1) begin
                    if (seg_head != HEAD_DOT) begin
                        put_sep();
                        put_byte(seg_head[7:0]);
                    end
                end else if (seg_cnt == 2) begin
                    if (seg_head == HEAD_DOTDOT) begin
                        // Step back to the previous slash, never past the root.
                        o = wr_pos;
                        while (o > 1 && norm_mem[o-1] != CH_SLASH) o--;
                        if (o > 1) o--;
                        wr_pos = o;
                    end else begin
                        put_sep();
                        put_byte(seg_head[15:8]);
                        put_byte(seg_head[7:0]);
                    end
                end
            end
            seg_cnt   = 0;
            seg_head  = '0;
            seg_start = wr_pos;
        endfunction

        function void note_request(logic op, logic [7:0] ch, logic last,
                                   logic [LEN_W-1:0] idx);
            t_result r;
            if (op == OP_READ) begin
                r.status = STATUS_OK;
                r.length = '0;
                r.data   = (err == STATUS_OK && idx < wr_pos) ? norm_mem[idx] : 8'h00;
                pending.push_back(r);
                return;
            end
            if (at_path_start) begin
                at_path_start = 1'b0;
                err      = STATUS_OK;
                wr_pos   = 0;
                seg_cnt  = 0;
                seg_head = '0;
                if (ch != CH_SLASH) begin
                    err = STATUS_NOT_ABS;
                end else begin
                    norm_mem[0] = CH_SLASH;
                    wr_pos = 1;
                end
                seg_start = wr_pos;
            end else if (err == STATUS_OK) begin
                if (ch == CH_SLASH) begin
                    close_segment();
                end else if (seg_cnt < 2) begin
                    if (seg_cnt == 0) seg_start = wr_pos;
                    seg_head = {seg_head[7:0], ch};
                    seg_cnt++;
                end else if (seg_cnt == 2) begin
                    // The first two bytes were held back in case of a dot segment.
                    put_sep();
                    put_byte(seg_head[15:8]);
                    put_byte(seg_head[7:0]);
                    put_byte(ch);
                    seg_cnt = 3;
                end else begin
                    put_byte(ch);
                end
            end
            if (last) begin
                if (err == STATUS_OK) close_segment();
                at_path_start = 1'b1;
                r.status = err;
                r.length = (err == STATUS_OK) ? LEN_W'(wr_pos) : '0;
                r.data   = 8'h00;
                pending.push_back(r);
            end
        endfunction

        function void check_result(logic [1:0] st, logic [LEN_W-1:0] len, logic [7:0] d);
            t_result e;
            if (pending.size() == 0) begin
                $error("unexpected result: status %0d length %0d data 0x%02h", st, len, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (len !== e.length) begin
                $error("length: expected %0d, got %0d", e.length, len);
                errors++;
            end
            if (d !== e.data) begin
                $error("data: expected 0x%02h, got 0x%02h", e.data, d);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic             i_op = OP_PATH;
    logic [7:0]       i_ch = CH_SLASH;
    logic             i_last = 1'b0;
    logic [LEN_W-1:0] i_index = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [1:0]       o_status;
    logic [LEN_W-1:0] o_length;
    logic [7:0]       o_data;

    path_scoreboard sb;
    int  req_sent = 0;
    int  results_seen = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  send_quiet = 1'b0;
    bit  mid_reads = 1'b0;
    int  stuck_cycles = 0;

    lexical_path_normalizer_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_op     (i_op),
        .i_ch     (i_ch),
        .i_last   (i_last),
        .i_index  (i_index),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_status (o_status),
        .o_length (o_length),
        .o_data   (o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] nonslash_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CH_SLASH);
        return c;
    endfunction

    function automatic logic [7:0] name_byte();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6) return 8'h61 + 8'($urandom_range(0, 25));
        if (k < 8) return CH_DOT;
        return nonslash_byte();
    endfunction

    // Mostly indexes inside a typical short path, sometimes anywhere.
    function automatic logic [LEN_W-1:0] pick_index();
        if ($urandom_range(0, 9) < 7) return LEN_W'($urandom_range(0, 40));
        return LEN_W'($urandom_range(0, BUF_LEN - 1));
    endfunction

    task automatic send_req(input logic op, input logic [7:0] ch, input logic last,
                            input logic [LEN_W-1:0] idx);
        if (!send_quiet) begin
            while ($urandom_range(0, 99) < 31) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_ch    <= ch;
        i_last  <= last;
        i_index <= idx;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(op, ch, last, idx);
        req_sent++;
    endtask

    task automatic send_read(input logic [LEN_W-1:0] idx);
        send_req(OP_READ, 8'($urandom), 1'($urandom), idx);
    endtask

    task automatic send_bytes(input logic [7:0] p [$]);
        for (int i = 0; i < p.size(); i++) begin
            if (mid_reads && $urandom_range(0, 15) == 0) send_read(pick_index());
            send_req(OP_PATH, p[i], i == p.size() - 1, LEN_W'($urandom));
        end
    endtask

    task automatic send_text(input string s);
        logic [7:0] p [$];
        for (int i = 0; i < s.len(); i++) p.push_back(s[i]);
        send_bytes(p);
    endtask

    task automatic send_random_path();
        logic [7:0] p [$];
        int n;
        if ($urandom_range(0, 9) == 0) begin
            // Loose bytes with the last flag scattered about.
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 2))
                    0: p.push_back(CH_SLASH);
                    1: p.push_back(CH_DOT);
                    default: p.push_back(8'($urandom_range(1, 255)));
                endcase
                if (i == n - 1 || $urandom_range(0, 3) == 0) begin
                    send_bytes(p);
                    p.delete();
                end
            end
            return;
        end
        p.push_back($urandom_range(0, 11) == 0 ? nonslash_byte() : CH_SLASH);
        repeat ($urandom_range(0, 7)) begin
            p.push_back(CH_SLASH);
            case ($urandom_range(0, 9))
                0: ;
                1, 2: p.push_back(CH_DOT);
                3, 4: begin
                    p.push_back(CH_DOT);
                    p.push_back(CH_DOT);
                end
                default: begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 5);
                    repeat (n) p.push_back(name_byte());
                end
            endcase
        end
        if ($urandom_range(0, 4) == 0) p.push_back(CH_SLASH);
        send_bytes(p);
        if ($urandom_range(0, 1) == 0) repeat ($urandom_range(1, 3)) send_read(pick_index());
    endtask

    // Result side: checks each accepted result, stalls at random, and holds
    // off once for a long stretch so that the block backs up.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_status, o_length, o_data);
            results_seen++;
        end
        if (!hold_done && results_seen == 60) begin
            hold_left = PRESSURE_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (results_seen >= 300 && results_seen < 500) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 31);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        int base;
        sb = new;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Short directed paths: root, dot and dot-dot handling, a path that
        // is not absolute, the extreme byte values and reads at both ends.
        send_read('0);
        send_text("/");
        send_text("//a/./bc/../d");
        send_read(LEN_W'(3));
        send_text("/..");
        send_text("xa/b");
        send_read(LEN_W'(BUF_LEN - 1));
        send_bytes({CH_SLASH, 8'h00, 8'hFF});

        mid_reads = 1'b1;
        base = req_sent;
        while (req_sent - base < RANDOM_REQS) begin
            send_quiet = (req_sent - base >= 200 && req_sent - base < 450);
            send_random_path();
        end
        send_quiet = 1'b0;
        i_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl
rtl/lpn_pkg.sv
rtl/lpn_ctrl.sv
rtl/lpn_datapath.sv
rtl/lexical_path_normalizer_unit.sv
sim/tb_lexical_path_normalizer_unit.sv
